/* rtl/pbpm_pkg.sv */
// ----------------------------------------------------------------------------
// pbpm_pkg: shared types and constants of the packet buffer pool manager
// Request codes, queue command bundle, controller states and field widths.
// ----------------------------------------------------------------------------
package pbpm_pkg;

  // Width of a buffer index as carried on the streams.
  localparam int IDX_W = 6;
  // Width of an occupancy field in a result.
  localparam int CNT_W = 7;
  // Width of the request kind field.
  localparam int REQ_W = 2;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_SUBMIT  = 2'd1,
    REQ_TAKE    = 2'd2,
    REQ_RELEASE = 2'd3
  } req_kind_t;

  // Controller states: wait for a request, then finish it once the head
  // entry has come back from memory.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } pbpm_state_t;

  // Command bundle from the controller to one queue.
  typedef struct packed {
    logic rd;    // read the head entry (data valid next cycle)
    logic pop;   // advance the head
    logic push;  // write at the tail
  } q_cmd_t;

endpackage

/* rtl/packet_buffer_pool_manager_core.sv */
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager_core: free list and ready queue of buffer indices
// Hands out buffer indices from a free queue and passes filled buffers
// through a ready queue, answering every request with status and counts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: a kind (allocate, submit, take,
//   release) and a buffer index for the push kinds. Each request yields
//   exactly one result on the out_ stream: ok, the granted index for a
//   successful pop, and both queue occupancies after the request. A pop from
//   an empty queue or a push into a full one returns ok = 0 and changes
//   nothing.
//   Timing: a request has two steps, one to read the queue head from its
//   memory and one to update the queue and load the result register, so the
//   block takes no new request until the current one has finished. The result
//   is registered and appears once the update step has loaded it.
//   Reset: the free queue holds indices 0 to POOL_SIZE-1 in order and the
//   ready queue is empty. No clearing pass is needed; a fill count stands in
//   for the seeded free list contents.
//   Stalls: the result register holds while out_tready is low. A new request
//   is still taken; it then waits in its update step until the result
//   register is free.
// ----------------------------------------------------------------------------
module packet_buffer_pool_manager_core
  import pbpm_pkg::*;
#(
  parameter int POOL_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] req_type, [7:2] buffer_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] ok, [6:1] granted_index,
                                  // [13:7] free_count, [20:14] ready_count,
                                  // [23:21] zero
);

  localparam int CW = $clog2(POOL_SIZE + 1);

  pbpm_state_t      state_r;
  pbpm_state_t      state_nxt;
  req_kind_t        kind_r;
  logic [IDX_W-1:0] index_r;
  logic             accept;
  logic             done;

  q_cmd_t           free_cmd;
  q_cmd_t           ready_cmd;
  logic             free_empty;
  logic             free_full;
  logic [CW-1:0]    free_occ;
  logic [CW-1:0]    free_occ_nxt;
  logic [IDX_W-1:0] free_data;
  logic             ready_empty;
  logic             ready_full;
  logic [CW-1:0]    ready_occ;
  logic [CW-1:0]    ready_occ_nxt;
  logic [IDX_W-1:0] ready_data;

  logic             ok;
  logic [IDX_W-1:0] granted;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_ok_r;
  logic [IDX_W-1:0] out_granted_r;
  logic [CNT_W-1:0] out_free_r;
  logic [CNT_W-1:0] out_ready_r;

  assign accept = in_tvalid && in_tready;
  // The request finishes once the result register can take its answer.
  assign done   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and queue commands. In idle the input is always ready, so a
  // valid request is a taken one.
  always_comb begin
    in_tready = 1'b0;
    free_cmd  = '0;
    ready_cmd = '0;
    ok        = 1'b0;
    granted   = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        free_cmd.rd  = in_tvalid;
        ready_cmd.rd = in_tvalid;
      end
      ST_EXEC: begin
        case (kind_r)
          REQ_ALLOC: begin
            ok           = !free_empty;
            free_cmd.pop = done;
            granted      = ok ? free_data : '0;
          end
          REQ_SUBMIT: begin
            ok             = !ready_full;
            ready_cmd.push = done;
          end
          REQ_TAKE: begin
            ok            = !ready_empty;
            ready_cmd.pop = done;
            granted       = ok ? ready_data : '0;
          end
          REQ_RELEASE: begin
            ok            = !free_full;
            free_cmd.push = done;
          end
          default: ok = 1'b0;
        endcase
      end
      default: in_tready = 1'b0;
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Captured request.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= req_kind_t'(in_tdata[1:0]);
      index_r <= in_tdata[7:2];
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (done) begin
      out_ok_r      <= ok;
      out_granted_r <= granted;
      out_free_r    <= CNT_W'(free_occ_nxt);
      out_ready_r   <= CNT_W'(ready_occ_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_ready_r, out_free_r, out_granted_r, out_ok_r};

  // Free list, seeded with the pool indices.
  pbpm_queue #(
    .DEPTH    (POOL_SIZE),
    .INIT_SEQ (1'b1)
  ) u_free_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (free_cmd),
    .push_data (index_r),
    .empty     (free_empty),
    .full      (free_full),
    .occ       (free_occ),
    .occ_nxt   (free_occ_nxt),
    .rd_data   (free_data)
  );

  // Ready queue, empty after reset.
  pbpm_queue #(
    .DEPTH    (POOL_SIZE),
    .INIT_SEQ (1'b0)
  ) u_ready_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ready_cmd),
    .push_data (index_r),
    .empty     (ready_empty),
    .full      (ready_full),
    .occ       (ready_occ),
    .occ_nxt   (ready_occ_nxt),
    .rd_data   (ready_data)
  );

  // A refused request leaves both occupancies as they were.
  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !ok) |=> ($stable(free_occ) && $stable(ready_occ)))
    else $error("refused request changed a queue occupancy");

  // A fresh result follows a request in its finishing cycle.
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_EXEC))
    else $error("result appeared without a finished request");

  // Neither queue ever exceeds the pool.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_occ <= CW'(POOL_SIZE)) && (ready_occ <= CW'(POOL_SIZE)))
    else $error("queue occupancy beyond pool size");

endmodule

/* rtl/pbpm_queue.sv */
// ----------------------------------------------------------------------------
// pbpm_queue: circular FIFO of buffer indices in a synchronous memory
// Head pointer and occupancy in flip-flops, entries in a one-port-write,
// one-port-read memory with a registered read. With INIT_SEQ set, an entry
// that was never written reads as its own slot number, tracked by a fill
// count since the tail only ever moves forward from slot zero.
// ----------------------------------------------------------------------------
module pbpm_queue
  import pbpm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter bit INIT_SEQ = 1'b0,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_cmd_t           cmd,
  input  logic [IDX_W-1:0] push_data,
  output logic             empty,
  output logic             full,
  output logic [CW-1:0]    occ,
  output logic [CW-1:0]    occ_nxt,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem_r [DEPTH];
  logic [IDX_W-1:0] rd_q_r;
  logic [AW-1:0]    head_r;
  logic [AW-1:0]    head_nxt;
  logic [CW-1:0]    occ_r;
  logic [CW:0]      tail_sum;
  logic [AW-1:0]    tail;
  logic             do_pop;
  logic             do_push;

  assign empty   = (occ_r == '0);
  assign full    = (occ_r == CW'(DEPTH));
  assign occ     = occ_r;
  assign do_pop  = cmd.pop && !empty;
  assign do_push = cmd.push && !full;

  // Tail slot is head plus occupancy, wrapped once at the depth.
  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(occ_r);
    if (tail_sum >= (CW+1)'(DEPTH)) begin
      tail = AW'(tail_sum - (CW+1)'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  // Next head and occupancy.
  always_comb begin
    head_nxt = head_r;
    if (do_pop) begin
      if (head_r == AW'(DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + 1'b1;
      end
    end
    occ_nxt = occ_r;
    if (do_push && !do_pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (do_pop && !do_push) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= INIT_SEQ ? CW'(DEPTH) : '0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // Entry memory with registered read of the head slot.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail] <= push_data;
    end
    if (cmd.rd) begin
      rd_q_r <= mem_r[head_r];
    end
  end

  generate
    if (INIT_SEQ) begin : g_seed
      logic [CW-1:0]    fill_r;
      logic             written_r;
      logic [IDX_W-1:0] seed_r;

      // Slots below the fill count have been written at least once.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fill_r <= '0;
        end else if (do_push && (fill_r != CW'(DEPTH))) begin
          fill_r <= fill_r + 1'b1;
        end
      end

      // Capture alongside the memory read whether the slot holds its seed.
      always_ff @(posedge clk) begin
        if (cmd.rd) begin
          written_r <= (CW'(head_r) < fill_r);
          seed_r    <= IDX_W'(head_r);
        end
      end

      assign rd_data = written_r ? rd_q_r : seed_r;
    end else begin : g_plain
      assign rd_data = rd_q_r;
    end
  endgenerate

endmodule
